// ----- rtl/wbrm_pkg.sv -----
// ----------------------------------------------------------------------------
// wbrm_pkg
// Shared types and constants for the windowed byte rate meter.
// ----------------------------------------------------------------------------
`default_nettype none

package wbrm_pkg;

    localparam int TimeW     = 32;
    localparam int BytesW    = 16;
    localparam int IntervalW = 16;
    localparam int RateW     = 32;
    localparam int AccumW    = 32;
    localparam int ProdW     = 42;
    localparam int MsPerS    = 1000;

    // main sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT
    } ctl_state_t;

    // what one packet does to the window
    typedef enum logic [2:0] {
        EV_HOLD,
        EV_OPEN,
        EV_ACCUM,
        EV_SKIP,
        EV_CLOSE
    } eval_t;

    // divider sequencer
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

// ----- rtl/wbrm_div.sv -----
// ----------------------------------------------------------------------------
// wbrm_div
// Bit-serial restoring divider, 42-bit dividend by 16-bit divisor, quotient
// saturated to 32 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wbrm_div
    import wbrm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [ProdW-1:0]     dividend,
    input  wire logic [IntervalW-1:0] divisor,
    output div_status_t               status,
    output logic [RateW-1:0]          quotient
);

    div_state_t             state_reg, state_next;
    logic [IntervalW-1:0]   divisor_reg;
    logic [IntervalW-1:0]   rem_reg, rem_next;
    logic [RateW-1:0]       quot_reg, quot_next;
    logic [4:0]             count_reg;
    logic                   sat;
    logic [IntervalW:0]     trial;
    logic [IntervalW:0]     diff;
    logic                   ge;

    // quotient overflows 32 bits when the upper dividend bits reach the divisor
    assign sat = {6'b0, dividend[ProdW-1:RateW]} >= divisor;

    assign trial = {rem_reg, quot_reg[RateW-1]};
    assign ge    = trial >= {1'b0, divisor_reg};
    assign diff  = trial - {1'b0, divisor_reg};

    always_comb begin
        rem_next  = ge ? diff[IntervalW-1:0] : trial[IntervalW-1:0];
        quot_next = {quot_reg[RateW-2:0], ge};
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            DIV_IDLE: begin
                if (start) begin
                    state_next = sat ? DIV_DONE : DIV_RUN;
                end
            end
            DIV_RUN: begin
                if (count_reg == 5'd0) begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE: begin
                state_next = DIV_IDLE;
            end
            default: begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_comb begin
        status.busy = (state_reg != DIV_IDLE);
        status.done = (state_reg == DIV_DONE);
        quotient    = quot_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            DIV_IDLE: begin
                if (start) begin
                    divisor_reg <= divisor;
                    count_reg   <= 5'd31;
                    if (sat) begin
                        quot_reg <= '1;
                    end else begin
                        rem_reg  <= {6'b0, dividend[ProdW-1:RateW]};
                        quot_reg <= dividend[RateW-1:0];
                    end
                end
            end
            DIV_RUN: begin
                rem_reg   <= rem_next;
                quot_reg  <= quot_next;
                count_reg <= count_reg - 5'd1;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/windowed_byte_rate_meter_top.sv -----
// ----------------------------------------------------------------------------
// windowed_byte_rate_meter_top
// Byte rate estimate over fixed millisecond windows of a packet stream.
// ----------------------------------------------------------------------------
// Each request on the s_ channel is one received packet: its arrival time in
// ms and its byte count. Every packet yields exactly one request on the m_
// channel with the current rate in bytes per second and a flag that is set
// when this packet closed a window and a new rate was computed.
// cfg_wr_en writes the window length in ms and clears the window state; zero
// turns updates off. Write it only while no packet is in flight.
// A packet that does not close a window goes from the idle state through the
// eval and emit states into the output register; one that closes a window also
// passes the divide start and wait states, where the serial divider produces
// one quotient bit per cycle (32 steps) for bytes*1000/interval.
// One packet is handled at a time; s_tready is high only in the idle state, so
// the next packet is accepted only once the last one has left the emit state.
// The result sits in an output register, so a new packet is accepted while an
// earlier result still waits. If the receiver stalls, the next result waits in
// the emit state and s_tready stays low.
// Reset (aresetn low, synchronous) clears the interval, the window state, the
// rate and any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_byte_rate_meter_top
    import wbrm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [IntervalW-1:0] cfg_wr_data,  // interval_ms
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [47:0]          s_tdata,      // [31:0] now_ms, [47:32] byte_count
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [31:0]               m_tdata,      // [31:0] rate_bytes_per_s
    output logic [0:0]                m_tuser       // [0] rate_updated
);

    ctl_state_t             state_reg, state_next;
    logic [IntervalW-1:0]   interval_reg;
    logic                   window_open_reg;
    logic [TimeW-1:0]       window_start_reg;
    logic [AccumW-1:0]      byte_accum_reg;
    logic [RateW-1:0]       current_rate_reg;
    logic [TimeW-1:0]       now_reg;
    logic [BytesW-1:0]      bytes_reg;
    logic                   upd_reg;
    logic [ProdW-1:0]       prod_reg;
    logic                   m_valid_reg;
    logic [RateW-1:0]       m_rate_reg;
    logic                   m_upd_reg;

    logic [TimeW-1:0]       elapsed;
    logic [IntervalW:0]     twice;
    logic [AccumW:0]        accum_sum;
    logic [AccumW-1:0]      accum_sat;
    logic [ProdW-1:0]       prod_next;
    eval_t                  ev;
    logic                   in_fire;
    logic                   emit_fire;
    logic                   div_start;
    div_status_t            div_stat;
    logic [RateW-1:0]       div_quot;

    wbrm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (interval_reg),
        .status   (div_stat),
        .quotient (div_quot)
    );

    assign elapsed   = now_reg - window_start_reg;
    assign twice     = {interval_reg, 1'b0};
    assign accum_sum = {1'b0, byte_accum_reg} + {17'b0, bytes_reg};
    assign accum_sat = accum_sum[AccumW] ? '1 : accum_sum[AccumW-1:0];
    assign prod_next = ProdW'(byte_accum_reg) * ProdW'(MsPerS);

    always_comb begin
        if (interval_reg == '0) begin
            ev = EV_HOLD;
        end else if (!window_open_reg) begin
            ev = EV_OPEN;
        end else if (elapsed < {16'b0, interval_reg}) begin
            ev = EV_ACCUM;
        end else if (elapsed > {15'b0, twice}) begin
            ev = EV_SKIP;
        end else begin
            ev = EV_CLOSE;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = (ev == EV_CLOSE) ? ST_DIV_START : ST_EMIT;
            end
            ST_DIV_START: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        div_start = (state_reg == ST_DIV_START);
        emit_fire = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);
        in_fire   = s_tready && s_tvalid;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_rate_reg;
    assign m_tuser[0] = m_upd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // window state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg     <= '0;
            window_open_reg  <= 1'b0;
            window_start_reg <= '0;
            byte_accum_reg   <= '0;
            current_rate_reg <= '0;
        end else if (cfg_wr_en) begin
            interval_reg     <= cfg_wr_data;
            window_open_reg  <= 1'b0;
            window_start_reg <= '0;
            byte_accum_reg   <= '0;
            current_rate_reg <= '0;
        end else if (state_reg == ST_EVAL) begin
            case (ev)
                EV_OPEN: begin
                    window_open_reg  <= 1'b1;
                    window_start_reg <= now_reg;
                    byte_accum_reg   <= {16'b0, bytes_reg};
                end
                EV_ACCUM: begin
                    byte_accum_reg <= accum_sat;
                end
                EV_SKIP: begin
                    current_rate_reg <= '0;
                    window_start_reg <= now_reg;
                    byte_accum_reg   <= {16'b0, bytes_reg};
                end
                default: begin
                end
            endcase
        end else if (state_reg == ST_DIV_WAIT && div_stat.done) begin
            current_rate_reg <= div_quot;
            window_start_reg <= window_start_reg + {16'b0, interval_reg};
            byte_accum_reg   <= {16'b0, bytes_reg};
        end
    end

    // packet capture and product
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            now_reg   <= s_tdata[31:0];
            bytes_reg <= s_tdata[47:32];
        end
        if (state_reg == ST_EVAL) begin
            upd_reg  <= 1'b0;
            prod_reg <= prod_next;
        end else if (state_reg == ST_DIV_WAIT && div_stat.done) begin
            upd_reg <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            m_rate_reg <= current_rate_reg;
            m_upd_reg  <= upd_reg;
        end
    end

    // divider only runs while the sequencer waits on it
    a_div_busy_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> (state_reg == ST_DIV_WAIT || state_reg == ST_EMIT))
        else $error("divider busy outside divide phase");

    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> state_reg == ST_DIV_WAIT)
        else $error("divider done while not waiting");

    // a closed window leaves the window open
    a_upd_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> window_open_reg)
        else $error("rate update with no open window");

    a_disabled_no_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL && interval_reg == '0) |=> state_reg == ST_EMIT && !upd_reg)
        else $error("disabled meter started a divide");

endmodule

`default_nettype wire

// ----- tb/sv/tb_windowed_byte_rate_meter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_byte_rate_meter_top
// Self-checking bench for the windowed byte rate meter.
// ----------------------------------------------------------------------------
// Packets are driven on the s_ stream and every result on the m_ stream is
// compared with a bench-side rate estimator. A short table covers the window
// open, accumulate, close and skip paths, timestamp wrap and backwards time,
// and the disabled and extreme intervals. Random phases follow, each with its
// own interval and timestamps steered around the window edges. A burst at
// the end drives the rate into saturation. Both sides
// idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------

module tb_windowed_byte_rate_meter_top
    import wbrm_pkg::*;
();

    localparam int unsigned MAX_GAP       = 12;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned REPORT_MAX    = 10;
    localparam int unsigned RANDOM_ITEMS  = 420;
    localparam int unsigned OVF_PACKETS   = 71;

    typedef struct packed {
        logic [RateW-1:0] rate;
        logic             updated;
    } rate_result_t;

    typedef enum logic {
        ROW_PKT,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [TimeW-1:0] stamp;    // packet time, or the interval for a register write
        logic [BytesW-1:0] bytes;
        logic             fixed;    // expected result typed in below
        logic [RateW-1:0] rate;
        logic             updated;
    } dir_row_t;

    localparam int unsigned DIR_ROWS = 22;
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{ROW_PKT, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'd0,        1'b0},  // disabled after reset
        '{ROW_CFG, 32'd1000,      16'd0,    1'b0, 32'd0,        1'b0},
        '{ROW_PKT, 32'd100,       16'd500,  1'b1, 32'd0,        1'b0},  // opens the window
        '{ROW_PKT, 32'd600,       16'd500,  1'b0, 32'd0,        1'b0},
        '{ROW_PKT, 32'd1100,      16'd200,  1'b1, 32'd1000,     1'b1},  // closes at one interval
        '{ROW_PKT, 32'd2099,      16'd0,    1'b0, 32'd0,        1'b0},
        '{ROW_PKT, 32'd3100,      16'd7,    1'b0, 32'd0,        1'b0},  // exactly two intervals
        '{ROW_PKT, 32'd4101,      16'd1,    1'b1, 32'd0,        1'b0},  // one past: skip
        '{ROW_PKT, 32'd4100,      16'd3,    1'b0, 32'd0,        1'b0},  // time went backwards
        '{ROW_CFG, 32'd65535,     16'd0,    1'b0, 32'd0,        1'b0},
        '{ROW_PKT, 32'hFFFF_FF00, 16'hFFFF, 1'b0, 32'd0,        1'b0},
        '{ROW_PKT, 32'h0000_0100, 16'd0,    1'b0, 32'd0,        1'b0},  // wrapped timestamp
        '{ROW_PKT, 32'h0000_FEFF, 16'd1,    1'b1, 32'd1000,     1'b1},
        '{ROW_PKT, 32'h0002_FEFE, 16'd0,    1'b1, 32'd0,        1'b0},
        '{ROW_CFG, 32'd1,         16'd0,    1'b0, 32'd0,        1'b0},
        '{ROW_PKT, 32'd0,         16'hFFFF, 1'b0, 32'd0,        1'b0},
        '{ROW_PKT, 32'd1,         16'd0,    1'b1, 32'd65535000, 1'b1},
        '{ROW_PKT, 32'd2,         16'd5,    1'b1, 32'd0,        1'b1},  // empty window closes
        '{ROW_PKT, 32'd5,         16'd9,    1'b0, 32'd0,        1'b0},
        '{ROW_CFG, 32'd0,         16'd0,    1'b0, 32'd0,        1'b0},
        '{ROW_PKT, 32'd12345,     16'd100,  1'b1, 32'd0,        1'b0},
        '{ROW_PKT, 32'd0,         16'd0,    1'b0, 32'd0,        1'b0}
    };

    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [IntervalW-1:0] cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [47:0]          s_tdata     = '0;     // [31:0] now_ms, [47:32] byte_count
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [31:0]          m_tdata;              // [31:0] rate_bytes_per_s
    logic [0:0]           m_tuser;              // [0] rate_updated

    windowed_byte_rate_meter_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // bench copy of the meter state
    logic [IntervalW-1:0] mtr_interval = '0;
    logic                 mtr_open     = 1'b0;
    logic [TimeW-1:0]     mtr_start    = '0;
    logic [AccumW-1:0]    mtr_accum    = '0;
    logic [RateW-1:0]     mtr_rate     = '0;

    rate_result_t pending_rates [$];

    bit          tx_idle      = 1'b1;
    bit          rx_idle      = 1'b1;
    bit          hold_request = 1'b0;
    int unsigned mismatches       = 0;
    int unsigned results_seen     = 0;
    int unsigned closes_seen      = 0;
    int unsigned packets_sent     = 0;
    int unsigned settings_written = 0;
    int unsigned stall_cycles     = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic rate_result_t predict_rate(input logic [TimeW-1:0] stamp,
                                                  input logic [BytesW-1:0] bytes);
        logic [TimeW-1:0]   elapsed;
        logic [16:0]        twice;
        logic [AccumW:0]    sum;
        logic [ProdW-1:0]   quot;
        rate_result_t       res;
        res.updated = 1'b0;
        if (mtr_interval != 0) begin
            if (!mtr_open) begin
                mtr_open  = 1'b1;
                mtr_start = stamp;
                mtr_accum = {16'd0, bytes};
            end else begin
                elapsed = stamp - mtr_start;
                twice   = {mtr_interval, 1'b0};
                if (elapsed < {16'd0, mtr_interval}) begin
                    sum       = {1'b0, mtr_accum} + {17'd0, bytes};
                    mtr_accum = sum[AccumW] ? '1 : sum[AccumW-1:0];
                end else if (elapsed > {15'd0, twice}) begin
                    // a whole window went by without packets
                    mtr_rate  = '0;
                    mtr_start = stamp;
                    mtr_accum = {16'd0, bytes};
                end else begin
                    quot = ({10'd0, mtr_accum} * 42'd1000) / {26'd0, mtr_interval};
                    mtr_rate    = (|quot[ProdW-1:RateW]) ? '1 : quot[RateW-1:0];
                    mtr_start   = mtr_start + {16'd0, mtr_interval};
                    mtr_accum   = {16'd0, bytes};
                    res.updated = 1'b1;
                end
            end
        end
        res.rate = mtr_rate;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch in %s of result %0d: expected %0d, got %0d",
                     what, results_seen, want, got);
    endtask

    always @(posedge aclk) begin : check_results
        rate_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser[0])
                closes_seen++;
            if (pending_rates.size() == 0) begin
                report_mismatch("unexpected result rate", 32'd0, m_tdata);
            end else begin
                want = pending_rates.pop_front();
                if (m_tdata !== want.rate)
                    report_mismatch("rate_bytes_per_s", want.rate, m_tdata);
                if (m_tuser[0] !== want.updated)
                    report_mismatch("rate_updated", {31'd0, want.updated}, {31'd0, m_tuser[0]});
            end
        end
    end

    initial begin : receiver
        int unsigned gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                gap = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic offer_packet(input logic [TimeW-1:0] stamp, input logic [BytesW-1:0] bytes,
                                input logic fixed, input rate_result_t fixed_res);
        int unsigned  gap;
        rate_result_t res;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {bytes, stamp};
        do @(posedge aclk); while (!s_tready);
        res = predict_rate(stamp, bytes);
        pending_rates.push_back(fixed ? fixed_res : res);
        packets_sent++;
    endtask

    // stop offering and let every outstanding result come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_rates.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_interval(input logic [IntervalW-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        mtr_interval = value;
        mtr_open     = 1'b0;
        mtr_start    = '0;
        mtr_accum    = '0;
        mtr_rate     = '0;
        settings_written++;
    endtask

    initial begin : stimulus
        int unsigned       iv;
        int unsigned       off;
        int unsigned       phase_len;
        int unsigned       random_sent;
        bit                pressure_done;
        logic [TimeW-1:0]  stamp;
        logic [BytesW-1:0] bytes;
        dir_row_t          row;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            row = DIR_TAB[i];
            if (row.kind == ROW_CFG)
                set_interval(row.stamp[IntervalW-1:0]);
            else
                offer_packet(row.stamp, row.bytes, row.fixed, '{row.rate, row.updated});
        end

        random_sent   = 0;
        pressure_done = 1'b0;
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 6))
                0:       iv = 0;
                1:       iv = 1;
                2:       iv = 65535;
                3:       iv = $urandom_range(2, 16);
                4, 5:    iv = $urandom_range(17, 2000);
                default: iv = $urandom_range(1, 65535);
            endcase
            set_interval(iv[IntervalW-1:0]);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if (!pressure_done) begin
                // receiver stalls while packets keep coming back to back
                tx_idle       = 1'b0;
                hold_request  = 1'b1;
                pressure_done = 1'b1;
            end
            phase_len = $urandom_range(20, 60);
            repeat (phase_len) begin
                if (iv == 0 || !mtr_open || $urandom_range(0, 15) == 0) begin
                    stamp = $urandom;
                end else begin
                    // land around the window edges relative to the current start
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: off = $urandom_range(0, iv - 1);
                        5:             off = iv;
                        6:             off = $urandom_range(iv, 2 * iv);
                        7:             off = 2 * iv;
                        8:             off = 2 * iv + 1;
                        default:       off = $urandom_range(2 * iv + 1, 4 * iv + 1);
                    endcase
                    stamp = mtr_start + off;
                end
                case ($urandom_range(0, 7))
                    0:       bytes = '0;
                    1:       bytes = '1;
                    default: bytes = BytesW'($urandom);
                endcase
                offer_packet(stamp, bytes, 1'b0, '0);
                random_sent++;
                if ($urandom_range(0, 39) == 0)
                    drain();
            end
        end

        // full-size packets in a 1 ms window push the rate past 32 bits
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        set_interval(16'd1);
        stamp = $urandom;
        repeat (OVF_PACKETS) offer_packet(stamp, 16'hFFFF, 1'b0, '0);
        offer_packet(stamp + 32'd1, BytesW'($urandom), 1'b0, '0);

        drain();
        $display("sent %0d packets over %0d interval settings, checked %0d results",
                 packets_sent, settings_written, results_seen);
        $display("%0d window closes seen, incl. a rate saturation burst",
                 closes_seen);
        if (mismatches == 0 && pending_rates.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
